/* rtl/kss_pkg.sv */
// Shared types and codes for the shared-store stack unit.
`timescale 1ns / 1ps
`default_nettype none

package kss_pkg;

    // Operation and status codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Request beat
    typedef struct packed {
        logic              action;
        logic [1:0]        stack_id;
        logic signed [31:0] push_value;
    } req_t;

    // Response beat
    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
    } rsp_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOP,
        ST_LINK,
        ST_COMMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic rd_top;
        logic rd_link;
        logic commit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_full;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/kss_ctrl.sv */
// Sequencing controller for the shared-store stack unit.
`timescale 1ns / 1ps
`default_nettype none

module kss_ctrl
    import kss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through top read, link read and commit
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_TOP;
                end
            end
            ST_TOP:
            begin
                state_next = ST_LINK;
            end
            ST_LINK:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!sts.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive commands
    always_comb
    begin
        req_ready   = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_TOP:
            begin
                cmd.rd_top = 1'b1;
            end
            ST_LINK:
            begin
                cmd.rd_link = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = !sts.out_full;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/kss_dp.sv */
// Datapath for the shared-store stack unit: stores, free list and response register.
`timescale 1ns / 1ps
`default_nettype none

module kss_dp
    import kss_pkg::*;
#(
    parameter int SLOTS  = 16,
    parameter int STACKS = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire cmd_t cmd,
    output sts_t      sts,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int AW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int TW = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam logic [LW-1:0] END_MARK = LW'(SLOTS);

    // Stores
    logic signed [31:0] values_mem [SLOTS];
    logic [LW-1:0]      links_mem  [SLOTS];
    logic [LW-1:0]      tops_mem   [STACKS];

    // Control state
    logic [STACKS-1:0] top_valid_reg;
    logic [LW-1:0]     free_head_reg;
    logic [LW-1:0]     fill_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    // Captured request and read results
    logic               act_reg;
    logic [1:0]         sid_reg;
    logic signed [31:0] val_reg;
    logic [LW-1:0]      top_rd_reg;
    logic               top_vld_reg;
    logic [LW-1:0]      link_rd_reg;
    logic signed [31:0] val_rd_reg;
    logic [AW-1:0]      slot_reg;
    logic               ok_reg;
    logic               fresh_reg;

    logic [TW-1:0] tidx;
    logic          sid_ok;
    logic [LW-1:0] top_eff;
    logic [LW-1:0] slot_sel;
    logic          ok_sel;
    logic [LW-1:0] link_eff;
    logic          do_push;
    logic          do_pop;

    assign tidx    = TW'(sid_reg);
    assign sid_ok  = 32'(sid_reg) < STACKS;
    assign top_eff = top_vld_reg ? top_rd_reg : END_MARK;

    // Pick the slot touched by this operation and whether it can proceed
    always_comb
    begin
        if (act_reg == ACT_PUSH)
        begin
            slot_sel = free_head_reg;
            ok_sel   = sid_ok && (free_head_reg < END_MARK);
        end
        else
        begin
            slot_sel = top_eff;
            ok_sel   = sid_ok && (top_eff < END_MARK);
        end
    end

    // A never-used slot links to its neighbor; clamp corrupt links to the end mark
    always_comb
    begin
        if (fresh_reg)
        begin
            link_eff = LW'(slot_reg) + LW'(1);
        end
        else if (link_rd_reg >= END_MARK)
        begin
            link_eff = END_MARK;
        end
        else
        begin
            link_eff = link_rd_reg;
        end
    end

    assign do_push = cmd.commit && ok_reg && (act_reg == ACT_PUSH);
    assign do_pop  = cmd.commit && ok_reg && (act_reg == ACT_POP);

    // Capture request and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= req.action;
            sid_reg <= req.stack_id;
            val_reg <= req.push_value;
        end
        if (cmd.rd_top)
        begin
            top_vld_reg <= sid_ok ? top_valid_reg[tidx] : 1'b0;
            if (sid_ok)
            begin
                top_rd_reg <= tops_mem[tidx];
            end
        end
        if (cmd.rd_link)
        begin
            ok_reg    <= ok_sel;
            slot_reg  <= AW'(slot_sel);
            fresh_reg <= (slot_sel == fill_reg);
            if (ok_sel)
            begin
                link_rd_reg <= links_mem[AW'(slot_sel)];
                val_rd_reg  <= values_mem[AW'(slot_sel)];
            end
        end
    end

    // Write the stores on commit
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            links_mem[slot_reg]  <= top_eff;
            values_mem[slot_reg] <= val_reg;
            tops_mem[tidx]       <= LW'(slot_reg);
        end
        if (do_pop)
        begin
            links_mem[slot_reg] <= free_head_reg;
            tops_mem[tidx]      <= link_eff;
        end
    end

    // Update free list head, fill count and top valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_valid_reg <= '0;
            free_head_reg <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (do_push)
            begin
                free_head_reg       <= link_eff;
                top_valid_reg[tidx] <= 1'b1;
                if (fresh_reg)
                begin
                    fill_reg <= fill_reg + LW'(1);
                end
            end
            if (do_pop)
            begin
                free_head_reg <= LW'(slot_reg);
            end
        end
    end

    // Hold the response beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (!ok_reg)
            begin
                rsp_reg.pop_value <= '0;
                rsp_reg.status    <= (act_reg == ACT_PUSH) ? STATUS_FULL : STATUS_EMPTY;
            end
            else
            begin
                rsp_reg.pop_value <= (act_reg == ACT_POP) ? val_rd_reg : '0;
                rsp_reg.status    <= STATUS_OK;
            end
        end
    end

    assign sts.out_full = rsp_valid_reg;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

endmodule

`default_nettype wire

/* rtl/k_stacks_shared_store_unit.sv */
// Top level of the shared-store stack unit.
`timescale 1ns / 1ps
`default_nettype none

// STACKS stacks share one store of SLOTS value slots. Free slots are chained
// through a link store from a free-list head; each stack is chained from its
// own top pointer. A push takes the free-list head slot, a pop returns the
// stack's top slot to the free list. Every request beat gives one response
// beat: pop_value (zero unless a pop succeeded) and status (ok, full, empty).
// Stack numbers at or beyond STACKS are refused as full on push, empty on pop.
// The unit handles one request at a time, stepping through capture,
// top-pointer read, link and value read and commit, set by the registered
// reads of the top store and the link store in sequence. The response is
// registered on commit; the next request can be accepted only after that
// commit, when the controller is back in its idle state. A finished
// response waits in an output register, and the next request may be accepted
// meanwhile; its commit waits until that response is taken. After reset the
// unit is ready at once: untouched slots are tracked by a fill count, so no
// clearing pass runs over the link store.
module k_stacks_shared_store_unit
    import kss_pkg::*;
#(
    parameter int SLOTS  = 16,
    parameter int STACKS = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    cmd_t cmd;
    sts_t sts;

    // Sequence each request
    kss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Stores and response register
    kss_dp #(
        .SLOTS  (SLOTS),
        .STACKS (STACKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
